// ===== hdl/plt_pkg.sv =====
// Shared types, register codes and constants for the power limited torque ramp.
`timescale 1ns / 1ps

package plt_pkg;

	// Register reset values
	localparam logic [15:0] POWER_RESET      = 16'd500;
	localparam logic [14:0] MAX_TORQUE_RESET = 15'd2400;
	localparam logic [14:0] THRESH_RESET     = 15'd0;
	localparam logic [15:0] STEPS_RESET      = 16'd100;

	// RPM to rad/s scaling, |speed| * 628 / 6000
	localparam logic [15:0] RPM_NUM = 16'd628;
	localparam logic [15:0] RPM_DEN = 16'd6000;

	// Serial step counts
	localparam logic [3:0] MUL_W_BITS = 4'd10;  // width of RPM_NUM
	localparam logic [3:0] MUL_R_BITS = 4'd15;  // width of limit - threshold
	localparam logic [5:0] DIV_W_BITS = 6'd25;  // scaled speed product
	localparam logic [5:0] DIV_P_BITS = 6'd16;  // power limit
	localparam logic [5:0] DIV_R_BITS = 6'd32;  // ramp product

	localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

	typedef enum logic [2:0] {
		REG_POWER_LIMIT    = 3'd0,
		REG_MAX_TORQUE     = 3'd1,
		REG_RAMP_THRESHOLD = 3'd2,
		REG_RAMP_STEPS     = 3'd3
	} plt_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_W,
		S_GO_W,
		S_DIV_W,
		S_GO_P,
		S_DIV_P,
		S_LIMIT,
		S_MUL_R,
		S_GO_R,
		S_DIV_R,
		S_DONE
	} plt_state_t;

	typedef struct packed {
		logic signed [15:0] pedal_req;
		logic signed [15:0] motor_speed;
	} plt_item_t;

	typedef struct packed {
		logic signed [15:0] torque_command;
		logic [14:0]        torque_limit;
		logic [14:0]        torque_cap;
		logic               limiting_active;
	} plt_result_t;

	typedef struct packed {
		logic        start;
		logic [5:0]  nbits;
		logic [31:0] dividend;  // left aligned: top nbits hold the value
		logic [15:0] divisor;
	} plt_div_ctl_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quotient;
	} plt_div_sts_t;

endpackage

// ===== hdl/plt_sdiv.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module plt_sdiv
	import plt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  plt_div_ctl_t ctl,
	output plt_div_sts_t sts
);

	logic [31:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] divisor_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [16:0] trial;
	logic [16:0] diff;
	logic        fits;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q     <= ctl.dividend;
			rem_q     <= '0;
			divisor_q <= ctl.divisor;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract when it fits
			rem_q <= fits ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign sts.busy     = busy_q;
	assign sts.done     = done_q;
	assign sts.quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q)
		else $error("divider started while busy");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && $past(busy_q) && (divisor_q != 16'd0) |-> rem_q < divisor_q)
		else $error("partial remainder not below divisor");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("done without a finished division");

endmodule

// ===== hdl/power_limited_torque_ramp_top.sv =====
// Top level of the power limited torque ramp: control sequencer and serial datapath.
`timescale 1ns / 1ps

// Usage:
//  item channel (item_valid / item_stall / item) takes one word with the pedal
//  torque and the signed motor speed; negative speed is forward rotation.
//  result channel (result_valid / result_stall / result) returns one word per item.
//  cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the four
//  registers; cfg_ready is always high, write only while the block is idle.
//  Forward words run through a shift-add multiplier and a restoring divider that
//  produce one bit per cycle: a multiply and a divide scale the speed, a second
//  divide turns the power limit into the torque limit, then a multiply and a
//  divide compute the ramp torque while the ramp is in progress. Zero or reverse
//  speed goes straight to the result, a near-zero forward speed skips the power
//  divide, and the ramp multiply and divide are skipped once the ramp has finished
//  or the limit is below the threshold. The block works on one word at a time; the
//  next word is taken once the previous result is registered.
//  A registered result waits while result_stall is high; the block still accepts
//  and works on the next word and holds it until the output register frees.
//  Reset clears the registers to their defaults, the tracked cap to 2400 and the
//  ramp counter to zero.
module power_limited_torque_ramp_top
	import plt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  plt_item_t   item,
	output logic        result_valid,
	input  logic        result_stall,
	output plt_result_t result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	plt_state_t state_q, state_d;

	logic [15:0] power_q;
	logic [14:0] max_torque_q;
	logic [14:0] thresh_q;
	logic [15:0] steps_q;

	logic [14:0] lowest_q;
	logic [16:0] cnt_q;

	logic [31:0] mul_acc_q;
	logic [31:0] mul_a_q;
	logic [15:0] mul_b_q;
	logic [3:0]  mul_cnt_q;

	logic signed [15:0] pedal_q;
	logic [14:0]        lim_q;
	plt_result_t        res_q;
	plt_result_t        result_q;
	logic               result_valid_q;

	plt_div_ctl_t div_ctl;
	plt_div_sts_t div_sts;

	logic        out_free;
	logic        result_load;
	logic [15:0] mag;
	logic [15:0] quo16;
	logic [19:0] quo_x10;
	logic [14:0] lim_div;
	logic [16:0] cnt_inc;
	logic [16:0] cnt_dec;
	logic [14:0] span;
	logic        take_cap;
	logic        ramp_done;
	logic        below;

	plt_sdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.sts    (div_sts)
	);

	assign out_free = !result_valid_q || !result_stall;
	assign mag      = ~item.motor_speed + 16'd1;
	assign quo16    = div_sts.quotient[15:0];
	assign quo_x10  = {1'b0, quo16, 3'b000} + {3'b000, quo16, 1'b0};
	assign lim_div  = (quo_x10 > {5'b0, max_torque_q}) ? max_torque_q : quo_x10[14:0];
	assign cnt_inc  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 17'd1;
	assign cnt_dec  = cnt_inc - 17'd1;
	assign span     = lim_q - thresh_q;
	assign take_cap = lim_q <= lowest_q;
	assign ramp_done = cnt_inc > {1'b0, steps_q};
	assign below    = lim_q < thresh_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid)
					state_d = item.motor_speed[15] ? S_MUL_W : S_DONE;
			end
			S_MUL_W: begin
				if (mul_cnt_q == 4'd1)
					state_d = S_GO_W;
			end
			S_GO_W: state_d = S_DIV_W;
			S_DIV_W: begin
				if (div_sts.done)
					state_d = (div_sts.quotient == '0) ? S_LIMIT : S_GO_P;
			end
			S_GO_P: state_d = S_DIV_P;
			S_DIV_P: begin
				if (div_sts.done)
					state_d = S_LIMIT;
			end
			S_LIMIT: state_d = (ramp_done || below) ? S_DONE : S_MUL_R;
			S_MUL_R: begin
				if (mul_cnt_q == 4'd1)
					state_d = S_GO_R;
			end
			S_GO_R: state_d = S_DIV_R;
			S_DIV_R: begin
				if (div_sts.done)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		item_stall       = state_q != S_IDLE;
		result_load      = 1'b0;
		div_ctl.start    = 1'b0;
		div_ctl.nbits    = DIV_R_BITS;
		div_ctl.dividend = mul_acc_q;
		div_ctl.divisor  = steps_q;
		case (state_q)
			S_GO_W: begin
				div_ctl.start    = 1'b1;
				div_ctl.nbits    = DIV_W_BITS;
				div_ctl.dividend = {mul_acc_q[24:0], 7'b0};
				div_ctl.divisor  = RPM_DEN;
			end
			S_GO_P: begin
				div_ctl.start    = 1'b1;
				div_ctl.nbits    = DIV_P_BITS;
				div_ctl.dividend = {power_q, 16'b0};
				div_ctl.divisor  = quo16;
			end
			S_GO_R: begin
				div_ctl.start = 1'b1;
			end
			S_DONE: result_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			power_q        <= POWER_RESET;
			max_torque_q   <= MAX_TORQUE_RESET;
			thresh_q       <= THRESH_RESET;
			steps_q        <= STEPS_RESET;
			lowest_q       <= MAX_TORQUE_RESET;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					REG_POWER_LIMIT:    power_q      <= cfg_data;
					REG_MAX_TORQUE:     max_torque_q <= cfg_data[14:0];
					REG_RAMP_THRESHOLD: thresh_q     <= cfg_data[14:0];
					REG_RAMP_STEPS:     steps_q      <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_IDLE && item_valid && !item.motor_speed[15])
				lowest_q <= max_torque_q;
			if (state_q == S_LIMIT) begin
				if (take_cap)
					lowest_q <= lim_q;
				// clear the count when the limit falls below the threshold mid-ramp
				cnt_q <= (!ramp_done && below) ? 17'd0 : cnt_inc;
			end
			if (result_load)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pedal_q <= item.pedal_req;
				mul_acc_q <= '0;
				mul_a_q   <= {16'b0, mag};
				mul_b_q   <= RPM_NUM;
				mul_cnt_q <= MUL_W_BITS;
				res_q.torque_command  <= item.pedal_req;
				res_q.torque_limit    <= '0;
				res_q.torque_cap      <= max_torque_q;
				res_q.limiting_active <= 1'b0;
			end
			S_MUL_W, S_MUL_R: begin
				if (mul_b_q[0])
					mul_acc_q <= mul_acc_q + mul_a_q;
				mul_a_q   <= {mul_a_q[30:0], 1'b0};
				mul_b_q   <= {1'b0, mul_b_q[15:1]};
				mul_cnt_q <= mul_cnt_q - 4'd1;
			end
			S_DIV_W: begin
				// near-zero scaled speed: take the ceiling, skip the power divide
				if (div_sts.done)
					lim_q <= max_torque_q;
			end
			S_DIV_P: begin
				if (div_sts.done)
					lim_q <= lim_div;
			end
			S_LIMIT: begin
				res_q.torque_limit    <= lim_q;
				res_q.torque_cap      <= take_cap ? lim_q : lowest_q;
				res_q.limiting_active <= 1'b1;
				if (ramp_done)
					res_q.torque_command <= signed'({1'b0, lim_q});
				else if (below)
					res_q.torque_command <= pedal_q;
				mul_acc_q <= '0;
				mul_a_q   <= {16'b0, cnt_dec[15:0]};
				mul_b_q   <= {1'b0, span};
				mul_cnt_q <= MUL_R_BITS;
			end
			S_DIV_R: begin
				if (div_sts.done)
					res_q.torque_command <= signed'({1'b0, thresh_q}
						+ {1'b0, div_sts.quotient[14:0]});
			end
			S_DONE: begin
				if (result_load)
					result_q <= res_q;
			end
			default: ;
		endcase
	end

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		result_load |=> result_valid_q && state_q == S_IDLE)
		else $error("finished word not presented");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LIMIT |=> cnt_q == 17'd0 || cnt_q >= $past(cnt_q))
		else $error("ramp counter stepped backward");

	a_ramp_divide: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV_R |-> cnt_q != 17'd0 && steps_q != 16'd0 && div_sts.busy
			|| div_sts.done)
		else $error("ramp division with zero count or steps");

endmodule
